/* hw/rtl/sle_pkg.sv */
// Shared types and constants for the sorted list engine.
`default_nettype none
package sle_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VAL_W     = 32;
	localparam int REQ_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int OUT_W     = 5;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_FIND   = 2'd1,
		REQ_DELETE = 2'd2
	} req_e_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE     = 2'd0,
		STAT_NOTFOUND = 2'd1,
		STAT_FULL     = 2'd2
	} status_e_t;

	typedef enum logic [2:0] {
		OP_HOLD    = 3'd0,
		OP_COMPARE = 3'd1,
		OP_SCAN    = 3'd2,
		OP_INSERT  = 3'd3,
		OP_DELETE  = 3'd4
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_CMP  = 2'd1,
		ST_SCAN = 2'd2,
		ST_RESP = 2'd3
	} state_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		cell_op_t          op;
		logic [VAL_W-1:0]  value;
	} cell_ctrl_t;

	// what one cell shows its neighbors
	typedef struct packed {
		logic [VAL_W-1:0]  val;
		logic              vld;
		logic              lt;
		logic              sh_lt;
		logic              sh_eq;
	} cell_link_t;

endpackage
`default_nettype wire

/* hw/rtl/sle_cell.sv */
// One list cell: holds one entry, compares it and shifts with its neighbors.
`default_nettype none
module sle_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sle_pkg::cell_ctrl_t ctrl,
	input  wire sle_pkg::cell_link_t left,
	input  wire sle_pkg::cell_link_t right,
	output sle_pkg::cell_link_t      self
);

	logic [sle_pkg::VAL_W-1:0] val_q;
	logic vld_q;
	logic lt_q;
	logic sh_lt_q;
	logic sh_eq_q;
	logic lt_c;
	logic eq_c;

	assign lt_c = vld_q && ($signed(val_q) < $signed(ctrl.value));
	assign eq_c = vld_q && (val_q == ctrl.value);

	// entry payload, no reset
	always_ff @(posedge clk) begin
		case (ctrl.op)
			sle_pkg::OP_INSERT: begin
				if (!lt_q) begin
					val_q <= left.lt ? ctrl.value : left.val;
				end
			end
			sle_pkg::OP_DELETE: begin
				if (!lt_q) begin
					val_q <= right.val;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			lt_q    <= 1'b0;
			sh_lt_q <= 1'b0;
			sh_eq_q <= 1'b0;
		end else begin
			case (ctrl.op)
				sle_pkg::OP_COMPARE: begin
					lt_q    <= lt_c;
					sh_lt_q <= lt_c;
					sh_eq_q <= eq_c;
				end
				sle_pkg::OP_SCAN: begin
					sh_lt_q <= right.sh_lt;
					sh_eq_q <= right.sh_eq;
				end
				sle_pkg::OP_INSERT: begin
					if (!lt_q) begin
						vld_q <= left.lt ? 1'b1 : left.vld;
					end
				end
				sle_pkg::OP_DELETE: begin
					if (!lt_q) begin
						vld_q <= right.vld;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign self.val   = val_q;
	assign self.vld   = vld_q;
	assign self.lt    = lt_q;
	assign self.sh_lt = sh_lt_q;
	assign self.sh_eq = sh_eq_q;

endmodule
`default_nettype wire

/* hw/rtl/sorted_list_engine.sv */
// Sorted list engine top level: request control and the chain of list cells.
// Sequence: accept, a compare state, then scan states that shift the compare flags
//   toward the head cell until the insertion point or first match reaches it, then a
//   response state that waits for the output register to be free.
// Requests are taken one at a time: in_stall stays high until the controller is idle.
// Reset (arst_n low, asynchronous): list empty, controller idle, no result pending.
`default_nettype none
module sorted_list_engine #(
	parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [sle_pkg::REQ_W-1:0]     req_type,
	input  wire logic signed [sle_pkg::VAL_W-1:0] value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [sle_pkg::STATUS_W-1:0]       status,
	output logic [sle_pkg::OUT_W-1:0]          position,
	output logic [sle_pkg::OUT_W-1:0]          count
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	sle_pkg::state_t state_q;
	sle_pkg::state_t state_nxt;

	logic [sle_pkg::REQ_W-1:0] req_q;
	logic [sle_pkg::VAL_W-1:0] value_q;
	logic [CNT_W-1:0]          fill_q;
	logic [CNT_W-1:0]          k_q;

	logic [sle_pkg::STATUS_W-1:0] res_status_q;
	logic [CNT_W-1:0]             res_pos_q;
	logic [CNT_W-1:0]             res_cnt_q;
	logic                         out_valid_q;
	logic [sle_pkg::STATUS_W-1:0] out_status_q;
	logic [sle_pkg::OUT_W-1:0]    out_pos_q;
	logic [sle_pkg::OUT_W-1:0]    out_cnt_q;

	sle_pkg::cell_ctrl_t ctrl;
	sle_pkg::cell_link_t links [DEPTH];
	sle_pkg::cell_link_t edge_left;
	sle_pkg::cell_link_t edge_right;
	logic [DEPTH-1:0]    vld_vec;

	logic accept;
	logic out_free;
	logic scan_hit;
	logic found;
	logic not_full;
	logic do_insert;
	logic do_delete;
	logic [sle_pkg::STATUS_W-1:0] hit_status;
	logic [CNT_W-1:0]             hit_pos;
	logic [CNT_W-1:0]             hit_cnt;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Head cell sees the flags of cell k during scan; the first cell whose entry is
	// not below the request marks the insertion point and the first possible match.
	assign scan_hit  = !links[0].sh_lt;
	assign found     = links[0].sh_eq;
	assign not_full  = fill_q < CNT_W'(DEPTH);
	assign do_insert = scan_hit && (req_q == sle_pkg::REQ_INSERT) && not_full;
	assign do_delete = scan_hit && (req_q == sle_pkg::REQ_DELETE) && found;

	// Result of the request, valid in the cycle the scan hits
	always_comb begin
		hit_status = sle_pkg::STAT_NOTFOUND;
		hit_pos    = '0;
		hit_cnt    = fill_q;
		case (req_q)
			sle_pkg::REQ_INSERT: begin
				if (not_full) begin
					hit_status = sle_pkg::STAT_DONE;
					hit_pos    = k_q + 1'b1;
					hit_cnt    = fill_q + 1'b1;
				end else begin
					hit_status = sle_pkg::STAT_FULL;
				end
			end
			sle_pkg::REQ_FIND: begin
				if (found) begin
					hit_status = sle_pkg::STAT_DONE;
					hit_pos    = k_q + 1'b1;
				end
			end
			sle_pkg::REQ_DELETE: begin
				if (found) begin
					hit_status = sle_pkg::STAT_DONE;
					hit_pos    = k_q + 1'b1;
					hit_cnt    = fill_q - 1'b1;
				end
			end
			default: begin
				// unused request code: ignore, report not found
			end
		endcase
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sle_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = sle_pkg::ST_CMP;
				end
			end
			sle_pkg::ST_CMP: begin
				state_nxt = sle_pkg::ST_SCAN;
			end
			sle_pkg::ST_SCAN: begin
				if (scan_hit) begin
					state_nxt = sle_pkg::ST_RESP;
				end
			end
			sle_pkg::ST_RESP: begin
				if (out_free) begin
					state_nxt = sle_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = sle_pkg::ST_IDLE;
			end
		endcase
	end

	// Controller outputs: input handshake and the command broadcast to the cells
	always_comb begin
		in_stall   = 1'b1;
		ctrl.op    = sle_pkg::OP_HOLD;
		ctrl.value = value_q;
		case (state_q)
			sle_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			sle_pkg::ST_CMP: begin
				ctrl.op = sle_pkg::OP_COMPARE;
			end
			sle_pkg::ST_SCAN: begin
				if (do_insert) begin
					ctrl.op = sle_pkg::OP_INSERT;
				end else if (do_delete) begin
					ctrl.op = sle_pkg::OP_DELETE;
				end else if (!scan_hit) begin
					ctrl.op = sle_pkg::OP_SCAN;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sle_pkg::ST_IDLE;
			fill_q      <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// clear the scan position at every request, advance it while scanning
			if (state_q == sle_pkg::ST_CMP) begin
				k_q <= '0;
			end else if (state_q == sle_pkg::ST_SCAN && !scan_hit) begin
				k_q <= k_q + 1'b1;
			end
			if (state_q == sle_pkg::ST_SCAN && scan_hit) begin
				fill_q <= hit_cnt;
			end
			// output register: load the pending result once the old beat is gone
			if (state_q == sle_pkg::ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req_type;
			value_q <= value;
		end
		if (state_q == sle_pkg::ST_SCAN && scan_hit) begin
			res_status_q <= hit_status;
			res_pos_q    <= hit_pos;
			res_cnt_q    <= hit_cnt;
		end
		if (state_q == sle_pkg::ST_RESP && out_free) begin
			out_status_q <= res_status_q;
			out_pos_q    <= sle_pkg::OUT_W'(res_pos_q);
			out_cnt_q    <= sle_pkg::OUT_W'(res_cnt_q);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign position  = out_pos_q;
	assign count     = out_cnt_q;

	// Chain ends: the left edge acts as a valid entry below everything, the right
	// edge as an empty slot, so insert and delete shift in the right values.
	assign edge_left.val   = '0;
	assign edge_left.vld   = 1'b1;
	assign edge_left.lt    = 1'b1;
	assign edge_left.sh_lt = 1'b0;
	assign edge_left.sh_eq = 1'b0;

	assign edge_right.val   = '0;
	assign edge_right.vld   = 1'b0;
	assign edge_right.lt    = 1'b0;
	assign edge_right.sh_lt = 1'b0;
	assign edge_right.sh_eq = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		sle_pkg::cell_link_t nb_left;
		sle_pkg::cell_link_t nb_right;
		if (i == 0) begin : g_first
			assign nb_left = edge_left;
		end else begin : g_mid_l
			assign nb_left = links[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign nb_right = edge_right;
		end else begin : g_mid_r
			assign nb_right = links[i+1];
		end
		sle_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.left   (nb_left),
			.right  (nb_right),
			.self   (links[i])
		);
		assign vld_vec[i] = links[i].vld;
	end

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((vld_vec >> 1) & ~vld_vec) == '0)
		else $error("list entries not packed from the head");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_vec) == int'(fill_q))
		else $error("valid cells disagree with fill count");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sle_pkg::ST_SCAN && do_insert) |=> fill_q == $past(fill_q) + 1'b1)
		else $error("insert did not grow the list");
`endif

endmodule
`default_nettype wire

/* dv/tb_sorted_list_engine.sv */
// Testbench for the sorted list engine: directed and random requests checked against a predictor.
`default_nettype none
module tb_sorted_list_engine;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH = sle_pkg::DEPTH_DEF;
	localparam int RAND_ITEMS = 1170;
	// request code that the block leaves unused; it must still answer
	localparam logic [sle_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam logic signed [sle_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [sle_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	// one answer of the block, as the predictor expects it
	typedef struct {
		sle_pkg::status_e_t            status;
		logic [sle_pkg::OUT_W-1:0]     position;
		logic [sle_pkg::OUT_W-1:0]     count;
	} outcome_t;

	logic                                  clk;
	logic                                  arst_n;
	logic                                  in_valid;
	logic                                  in_stall;
	logic [sle_pkg::REQ_W-1:0]             req_type;
	logic signed [sle_pkg::VAL_W-1:0]      value;
	logic                                  out_valid;
	logic                                  out_stall;
	logic [sle_pkg::STATUS_W-1:0]          status;
	logic [sle_pkg::OUT_W-1:0]             position;
	logic [sle_pkg::OUT_W-1:0]             count;

	// predictor copy of the list: ascending values and how many are held
	logic signed [sle_pkg::VAL_W-1:0]      list_vals [LIST_DEPTH];
	int                                    list_fill;

	// answers still owed by the block, oldest first
	outcome_t                              pending_answers [$];
	int                                    mismatch_count;
	// no random idling on either side while set
	bit                                    quiet;

	sorted_list_engine #(
		.DEPTH(LIST_DEPTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.position  (position),
		.count     (count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: far beyond the slowest correct run.
	initial begin
		#3ms;
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Apply one request to the predictor list and return the answer it must produce.
	function automatic outcome_t predict_request(input logic [sle_pkg::REQ_W-1:0] kind,
	                                             input logic signed [sle_pkg::VAL_W-1:0] val);
		outcome_t ans;
		int slot;
		ans.status   = sle_pkg::STAT_NOTFOUND;
		ans.position = '0;
		slot = -1;
		case (kind)
			sle_pkg::REQ_INSERT: begin
				if (list_fill >= LIST_DEPTH) begin
					ans.status = sle_pkg::STAT_FULL;
				end else begin
					// go in front of the first value that is not smaller
					slot = 0;
					while (slot < list_fill && list_vals[slot] < val)
						slot++;
					for (int k = list_fill; k > slot; k--)
						list_vals[k] = list_vals[k-1];
					list_vals[slot] = val;
					list_fill++;
					ans.status   = sle_pkg::STAT_DONE;
					ans.position = sle_pkg::OUT_W'(slot + 1);
				end
			end
			sle_pkg::REQ_FIND, sle_pkg::REQ_DELETE: begin
				for (int k = list_fill - 1; k >= 0; k--)
					if (list_vals[k] == val)
						slot = k;
				if (slot >= 0) begin
					if (kind == sle_pkg::REQ_DELETE) begin
						// close the gap left by the removed value
						for (int k = slot; k < list_fill - 1; k++)
							list_vals[k] = list_vals[k+1];
						list_fill--;
					end
					ans.status   = sle_pkg::STAT_DONE;
					ans.position = sle_pkg::OUT_W'(slot + 1);
				end
			end
			default: begin
				// unused code: leave the list alone, answer not found
			end
		endcase
		ans.count = sle_pkg::OUT_W'(list_fill);
		return ans;
	endfunction

	// Scoreboard. Predict on every accepted request beat, then check every
	// accepted result beat against the oldest outstanding answer.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				pending_answers.push_back(predict_request(req_type, value));
			if (out_valid && !out_stall) begin
				if (pending_answers.size() == 0) begin
					report_mismatch("result beat with nothing pending (status)", status, -1);
				end else begin
					want = pending_answers.pop_front();
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (position !== want.position)
						report_mismatch("position", position, want.position);
					if (count !== want.count)
						report_mismatch("count", count, want.count);
				end
			end
		end
	end

	// Receiver back-pressure: stall at random with a 9 percent chance unless quiet.
	always @(negedge clk) begin
		out_stall <= !quiet && ($urandom_range(0, 99) < 9);
	end

	// Send one request beat. Drop valid for random idle cycles first, then
	// hold the payload until the block takes it. Valid stays high on return
	// so back-to-back requests do not toggle it.
	task automatic send_req(input logic [sle_pkg::REQ_W-1:0] kind,
	                        input logic signed [sle_pkg::VAL_W-1:0] val);
		while (!quiet && $urandom_range(0, 99) < 9) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		req_type = kind;
		value    = val;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// Requests against an empty list: nothing to find or remove.
	task automatic test_empty_list();
		send_req(sle_pkg::REQ_FIND, 32'sd0);
		send_req(sle_pkg::REQ_DELETE, VAL_MIN);
	endtask

	// Extremes, equal values and the full-list refusal.
	task automatic test_insert_order();
		send_req(sle_pkg::REQ_INSERT, VAL_MAX);
		send_req(sle_pkg::REQ_INSERT, VAL_MIN);
		send_req(sle_pkg::REQ_INSERT, 32'sd0);
		send_req(sle_pkg::REQ_INSERT, -32'sd1);
		send_req(sle_pkg::REQ_INSERT, 32'sd1);
		// equal values: each new zero lands in front of the stored zeros
		send_req(sle_pkg::REQ_INSERT, 32'sd0);
		send_req(sle_pkg::REQ_INSERT, 32'sd0);
		send_req(sle_pkg::REQ_INSERT, 32'sd100);
		send_req(sle_pkg::REQ_INSERT, -32'sd100);
		send_req(sle_pkg::REQ_INSERT, 32'sd50);
		send_req(sle_pkg::REQ_INSERT, -32'sd50);
		send_req(sle_pkg::REQ_INSERT, 32'sd7);
		send_req(sle_pkg::REQ_INSERT, -32'sd7);
		send_req(sle_pkg::REQ_INSERT, 32'sh4000_0000);
		send_req(sle_pkg::REQ_INSERT, -32'sh4000_0000);
		send_req(sle_pkg::REQ_INSERT, 32'sd3);
		// list is now full: refuse this one
		send_req(sle_pkg::REQ_INSERT, 32'sd2);
	endtask

	// Finds and deletes at both ends, on duplicates and on missing values, plus an unused request code.
	task automatic test_lookup_and_remove();
		send_req(sle_pkg::REQ_FIND, VAL_MIN);
		send_req(sle_pkg::REQ_FIND, VAL_MAX);
		send_req(sle_pkg::REQ_FIND, 32'sd0);
		send_req(sle_pkg::REQ_FIND, 32'sd5);
		send_req(REQ_UNUSED, 32'sd0);
		send_req(sle_pkg::REQ_DELETE, 32'sd0);
		send_req(sle_pkg::REQ_DELETE, VAL_MAX);
		send_req(sle_pkg::REQ_DELETE, VAL_MIN);
		send_req(sle_pkg::REQ_DELETE, 32'sd12345);
		send_req(sle_pkg::REQ_INSERT, 32'sd2);
	endtask

	// Random traffic. Alternate growing and shrinking phases so the list
	// keeps sweeping between empty and full; draw values mostly from the
	// list itself or a narrow band so finds, deletes and duplicates hit.
	task automatic test_random_traffic();
		int roll;
		bit growing;
		logic [sle_pkg::REQ_W-1:0] kind;
		logic signed [sle_pkg::VAL_W-1:0] val;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			// a long stretch with no idling on either side
			quiet   = (n >= 400 && n < 600);
			growing = ((n / 60) % 2 == 0);
			roll = $urandom_range(0, 99);
			if (roll < 4)
				kind = REQ_UNUSED;
			else if (roll < (growing ? 64 : 28))
				kind = sle_pkg::REQ_INSERT;
			else if (roll < (growing ? 82 : 54))
				kind = sle_pkg::REQ_FIND;
			else
				kind = sle_pkg::REQ_DELETE;
			roll = $urandom_range(0, 99);
			if (roll < 45 && list_fill > 0)
				val = list_vals[$urandom_range(0, list_fill - 1)];
			else if (roll < 75)
				val = sle_pkg::VAL_W'(int'($urandom_range(0, 16)) - 8);
			else if (roll < 82)
				val = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
			else
				val = $urandom;
			send_req(kind, val);
		end
		quiet = 1'b0;
	endtask

	// Drain: wait for every owed answer, then wait on for longer than a full-depth scan so a
	// stray extra result beat would still be caught.
	task automatic finish_run();
		in_valid = 1'b0;
		while (pending_answers.size() > 0)
			@(posedge clk);
		repeat (LIST_DEPTH + 8) @(posedge clk);
		if (pending_answers.size() > 0)
			report_mismatch("answers never returned", 0, pending_answers.size());
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		req_type       = sle_pkg::REQ_INSERT;
		value          = '0;
		out_stall      = 1'b0;
		quiet          = 1'b0;
		mismatch_count = 0;
		list_fill      = 0;
		foreach (list_vals[k])
			list_vals[k] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_list();
		test_insert_order();
		test_lookup_and_remove();
		test_random_traffic();
		finish_run();

		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
